// ===== rtl/spo_pkg.sv =====
// Shared types and constants for the shuffled play order block.
// No dependencies.
package spo_pkg;
  localparam logic [1:0] OP_ARRANGE  = 2'd0;
  localparam logic [1:0] OP_NEXT     = 2'd1;
  localparam logic [1:0] OP_PREVIOUS = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] REG_TRACK_COUNT  = 2'd0;
  localparam logic [1:0] REG_SHUFFLE_MODE = 2'd1;
  localparam logic [1:0] REG_LOOP_ALL     = 2'd2;
  localparam logic [1:0] REG_RANDOM_SEED  = 2'd3;

  localparam int MAX_TRACKS = 1024;
  localparam int ADDR_W  = $clog2(MAX_TRACKS);
  localparam int TRACK_W = 10;
  localparam int COUNT_W = 11;
  localparam int SEED_W  = 32;

  // Result word, lowest bit first: ok, track_index, can_next, can_previous.
  typedef struct packed {
    logic              can_previous;
    logic              can_next;
    logic [TRACK_W-1:0] track_index;
    logic              ok;
  } result_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction
endpackage

// ===== rtl/spo_modulo.sv =====
// Bit-serial remainder unit: one quotient bit per cycle over a 32-bit dividend.
// Does not use spo_pkg; standalone.
module spo_modulo #(
  parameter int DIV_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);
  logic [31:0]    dvd;
  logic [DIV_W:0] rem;
  logic [5:0]     cnt;
  logic           busy;
  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;

  assign shifted = {rem[DIV_W-1:0], dvd[31]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
        rem  <= '0;
        cnt  <= 6'd32;
      end else if (busy) begin
        dvd <= {dvd[30:0], 1'b0};
        rem <= diff[DIV_W] ? shifted : diff;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[DIV_W-1:0];
endmodule

// ===== rtl/shuffled_play_order.sv =====
// Shuffled play order: order table memory, sequencer, xorshift source.
// Depends on spo_pkg and spo_modulo.
//
// Channels: s_axis carries an operation word (op, current_track); m_axis
// returns one result word per operation (ok, track_index, can_next,
// can_previous). cfg_we/cfg_index/cfg_data write the four registers;
// the user must do so while the block is idle, which it does not enforce.
// s_axis_tready is low during a write. Next and previous go through S_RD_OUT
// (registered table read) and S_OUT (result register) to the result word.
// Arrange writes one table entry per cycle unless a register write stalls
// it; to shuffle it then does one swap per step: the 32-step serial
// remainder unit draws, then the two entries are read and written back. A
// next that wraps in shuffle mode reshuffles the whole table the same way,
// plus one more draw and swap when the last track must move off the front.
// Reset clears the play position and ready flag and loads seed 1; the table
// is undefined until an arrange fills it. One word is handled at a time;
// s_axis_tready is low while busy or while a result waits. A stalled
// receiver holds the result register and keeps the input closed.
module shuffled_play_order (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], current_track[11:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // ok[0], track_index[10:1], can_next[11], can_previous[12]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import spo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_LAST, S_MIX_TEST, S_MIX_WAIT, S_MIX_RD, S_MIX_WR, S_MIX_WR2,
    S_FIX_RD, S_FIX_CHK, S_FIX_WAIT, S_FIX_PRD, S_FIX_W0, S_FIX_W1, S_RD_OUT, S_OUT
  } state_t;

  state_t state;
  logic [TRACK_W-1:0] mem [MAX_TRACKS];
  logic [TRACK_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [TRACK_W-1:0] wdata;

  logic [COUNT_W-1:0] track_count;
  logic               shuffle_mode;
  logic               loop_all;
  logic [SEED_W-1:0]  rnd;
  logic [SEED_W-1:0]  rnd_next;
  logic [ADDR_W-1:0]  pos;
  logic               ready;

  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] n_dec;
  logic [COUNT_W-1:0] i;        // upper bound of the span still to mix
  logic [COUNT_W-1:0] i_dec;
  logic               lo;       // span low: 0 or 1
  logic [COUNT_W-1:0] lo_ext;
  logic               mix_more;
  logic               fix_need;
  logic [ADDR_W-1:0]  pick;
  logic [ADDR_W-1:0]  cur_pos;
  logic [COUNT_W-1:0] pick_sum;
  logic [COUNT_W-1:0] pos_inc;
  logic [TRACK_W-1:0] held;
  logic [TRACK_W-1:0] last;
  logic               ok;
  logic               mod_start;
  logic               mod_done;
  logic [COUNT_W-1:0] mod_div;
  logic [COUNT_W-1:0] mod_rem;
  result_t            res;

  logic               s_acc;
  logic [1:0]         op_in;
  logic [TRACK_W-1:0] cur_in;

  assign n = (track_count > COUNT_W'(MAX_TRACKS)) ? COUNT_W'(MAX_TRACKS) : track_count;
  assign n_dec    = n - COUNT_W'(1);
  assign rnd_next = xorshift(rnd);
  assign i_dec    = i - COUNT_W'(1);
  assign lo_ext   = {{(COUNT_W-1){1'b0}}, lo};
  assign mix_more = i > (lo_ext + COUNT_W'(1));
  assign pos_inc  = {1'b0, pos} + COUNT_W'(1);
  assign fix_need = (n > COUNT_W'(1)) && (rdata == last);
  assign pick_sum = mod_rem + ((state == S_FIX_WAIT) ? COUNT_W'(1) : lo_ext);

  assign mod_start = ((state == S_MIX_TEST) && mix_more) || ((state == S_FIX_CHK) && fix_need);
  assign mod_div   = ((state == S_FIX_CHK) || (state == S_FIX_WAIT)) ? n_dec : (i - lo_ext);

  spo_modulo #(.DIV_W(COUNT_W)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(rnd_next),
    .divisor(mod_div), .done(mod_done), .remainder(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign op_in  = s_axis_tdata[1:0];
  assign cur_in = s_axis_tdata[11:2];
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid && !cfg_we;

  always_comb begin
    we    = 1'b0;
    waddr = i_dec[ADDR_W-1:0];
    wdata = rdata;
    raddr = pos;
    case (state)
      S_FILL: begin
        we    = 1'b1;
        waddr = i[ADDR_W-1:0];
        wdata = i[TRACK_W-1:0];
        if (shuffle_mode) begin
          // start track to the front, track 0 to its place
          if (i == '0) wdata = cur_pos;
          else if (i[ADDR_W-1:0] == cur_pos) wdata = '0;
        end
      end
      S_MIX_TEST, S_MIX_WAIT: raddr = i_dec[ADDR_W-1:0];
      S_MIX_RD: raddr = pick;
      S_MIX_WR: we = 1'b1;
      S_MIX_WR2: begin
        we    = 1'b1;
        waddr = pick;
        wdata = held;
      end
      S_FIX_RD, S_FIX_CHK: raddr = '0;
      S_FIX_PRD: raddr = pick;
      S_FIX_W0: begin
        we    = 1'b1;
        waddr = '0;
      end
      S_FIX_W1: begin
        we    = 1'b1;
        waddr = pick;
        wdata = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; track_count <= '0; shuffle_mode <= 1'b0;
      loop_all <= 1'b0; rnd <= 32'd1; pos <= '0; ready <= 1'b0;
      m_axis_tvalid <= 1'b0; ok <= 1'b0; lo <= 1'b0; i <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TRACK_COUNT: begin
            track_count <= cfg_data[COUNT_W-1:0]; ready <= 1'b0; pos <= '0;
          end
          REG_SHUFFLE_MODE: shuffle_mode <= cfg_data[0];
          REG_LOOP_ALL:     loop_all <= cfg_data[0];
          REG_RANDOM_SEED:  rnd <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end else begin
        case (state)
          S_IDLE: begin
            if (s_acc) begin
              ok <= 1'b0;
              case (op_in)
                OP_ARRANGE: begin
                  if (n != '0 && {1'b0, cur_in} < n) begin
                    cur_pos <= cur_in; i <= '0; state <= S_FILL;
                  end else begin
                    state <= S_OUT;
                  end
                end
                OP_NEXT: begin
                  if (ready && n != '0) begin
                    if (pos_inc < n) begin
                      pos <= pos + ADDR_W'(1); ok <= 1'b1; state <= S_RD_OUT;
                    end else if (loop_all) begin
                      ok <= 1'b1;
                      // the read of the last-played entry is already under way
                      if (shuffle_mode) begin
                        state <= S_LAST;
                      end else begin
                        pos <= '0; state <= S_RD_OUT;
                      end
                    end else begin
                      state <= S_OUT;
                    end
                  end else begin
                    state <= S_OUT;
                  end
                end
                OP_PREVIOUS: begin
                  if (ready && n != '0) begin
                    if (pos != '0) begin
                      pos <= pos - ADDR_W'(1); ok <= 1'b1; state <= S_RD_OUT;
                    end else if (loop_all && !shuffle_mode && n > COUNT_W'(1)) begin
                      pos <= n_dec[ADDR_W-1:0]; ok <= 1'b1; state <= S_RD_OUT;
                    end else begin
                      state <= S_OUT;
                    end
                  end else begin
                    state <= S_OUT;
                  end
                end
                default: state <= S_OUT;
              endcase
            end
          end
          S_FILL: begin
            if ((i + COUNT_W'(1)) == n) begin
              ready <= 1'b1; ok <= 1'b1;
              if (shuffle_mode) begin
                lo <= 1'b1; i <= n; state <= S_MIX_TEST;
              end else begin
                pos <= cur_pos; state <= S_RD_OUT;
              end
            end else begin
              i <= i + COUNT_W'(1);
            end
          end
          S_LAST: begin
            last <= rdata; lo <= 1'b0; i <= n; state <= S_MIX_TEST;
          end
          S_MIX_TEST: begin
            if (mix_more) begin
              rnd <= rnd_next; state <= S_MIX_WAIT;
            end else if (lo) begin
              pos <= '0; state <= S_RD_OUT;
            end else begin
              state <= S_FIX_RD;
            end
          end
          S_MIX_WAIT: begin
            if (mod_done) begin
              held <= rdata; pick <= pick_sum[ADDR_W-1:0]; state <= S_MIX_RD;
            end
          end
          S_MIX_RD: state <= S_MIX_WR;
          S_MIX_WR: state <= S_MIX_WR2;
          S_MIX_WR2: begin
            i <= i_dec; state <= S_MIX_TEST;
          end
          S_FIX_RD: state <= S_FIX_CHK;
          S_FIX_CHK: begin
            // keep the track just played off the front
            if (fix_need) begin
              rnd <= rnd_next; state <= S_FIX_WAIT;
            end else begin
              pos <= '0; state <= S_RD_OUT;
            end
          end
          S_FIX_WAIT: begin
            if (mod_done) begin
              pick <= pick_sum[ADDR_W-1:0]; state <= S_FIX_PRD;
            end
          end
          S_FIX_PRD: state <= S_FIX_W0;
          S_FIX_W0: state <= S_FIX_W1;
          S_FIX_W1: begin
            pos <= '0; state <= S_RD_OUT;
          end
          S_RD_OUT: state <= S_OUT;
          S_OUT: begin
            res.ok <= ok;
            res.track_index <= ok ? rdata : '0;
            if (ready && n != '0) begin
              res.can_next <= (pos_inc < n) || (loop_all && n > COUNT_W'(1));
              res.can_previous <= (pos != '0) ||
                                  (loop_all && !shuffle_mode && n > COUNT_W'(1));
            end else begin
              res.can_next <= 1'b0; res.can_previous <= 1'b0;
            end
            m_axis_tvalid <= 1'b1; state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign m_axis_tdata = {3'b0, res};

  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while a result waits");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");
  a_ok_ready: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.ok) |-> ready) else $error("ok without table");
endmodule

// ===== sim/spo_checker.sv =====
// Watches the operation, result and register write channels of the play order block,
// predicts each result word and compares it field by field. Depends on spo_pkg.
module spo_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], current_track[11:2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // ok[0], track_index[10:1], can_next[11], can_previous[12]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          results_seen
);
  import spo_pkg::*;

  logic [TRACK_W-1:0] order_q [0:MAX_TRACKS-1];
  int unsigned        pos_q;
  logic [31:0]        rng_q;
  bit                 ready_q;
  logic [COUNT_W-1:0] count_q;
  bit                 shuffle_q;
  bit                 repeat_q;
  result_t            expected_q [$];

  function automatic int unsigned live_tracks();
    return (count_q > COUNT_W'(MAX_TRACKS)) ? MAX_TRACKS : int'(count_q);
  endfunction

  task automatic draw_below(input int unsigned bound, output int unsigned pick);
    logic [31:0] x;
    x = rng_q;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_q = x;
    pick = (bound == 0) ? 0 : x % bound;
  endtask

  task automatic shuffle_span(input int unsigned lo, input int unsigned n);
    int unsigned        i;
    int unsigned        pick;
    logic [TRACK_W-1:0] held;
    for (i = n; i > lo + 1; i--) begin
      draw_below(i - lo, pick);
      pick = pick + lo;
      held = order_q[i-1];
      order_q[i-1] = order_q[pick];
      order_q[pick] = held;
    end
  endtask

  task automatic predict_word(input logic [1:0] op, input logic [9:0] cur);
    int unsigned        n;
    int unsigned        pick;
    logic [TRACK_W-1:0] last;
    result_t            r;
    n = live_tracks();
    r = '0;
    case (op)
      OP_ARRANGE: begin
        if (n > 0 && cur < n) begin
          for (int i = 0; i < n; i++) order_q[i] = i[9:0];
          if (!shuffle_q) begin
            pos_q = cur;
          end else begin
            order_q[cur] = '0;
            order_q[0] = cur;
            shuffle_span(1, n);
            pos_q = 0;
          end
          ready_q = 1;
          r.ok = 1;
        end
      end
      OP_NEXT: begin
        if (ready_q && n > 0) begin
          if (pos_q + 1 < n) begin
            pos_q++;
            r.ok = 1;
          end else if (repeat_q) begin
            if (shuffle_q) begin
              // new cycle: full reshuffle, keep the last track off the front
              last = order_q[pos_q];
              shuffle_span(0, n);
              if (n > 1 && order_q[0] == last) begin
                draw_below(n - 1, pick);
                pick++;
                order_q[0] = order_q[pick];
                order_q[pick] = last;
              end
            end
            pos_q = 0;
            r.ok = 1;
          end
        end
      end
      OP_PREVIOUS: begin
        if (ready_q && n > 0) begin
          if (pos_q > 0) begin
            pos_q--;
            r.ok = 1;
          end else if (repeat_q && !shuffle_q && n > 1) begin
            pos_q = n - 1;
            r.ok = 1;
          end
        end
      end
      default: ;
    endcase
    if (r.ok) r.track_index = order_q[pos_q];
    if (ready_q && n > 0) begin
      r.can_next = (pos_q + 1 < n) || (repeat_q && n > 1);
      r.can_previous = (pos_q > 0) || (repeat_q && !shuffle_q && n > 1);
    end
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    result_t e;
    result_t g;
    if (rst) begin
      pos_q = 0;
      rng_q = 32'd1;
      ready_q = 0;
      count_q = '0;
      shuffle_q = 0;
      repeat_q = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        g = m_axis_tdata[12:0];
        results_seen++;
        if (expected_q.size() == 0) begin
          report("unexpected result word", 0, 1);
        end else begin
          e = expected_q.pop_front();
          if (g.ok !== e.ok) report("ok", e.ok, g.ok);
          if (g.track_index !== e.track_index)
            report("track_index", e.track_index, g.track_index);
          if (g.can_next !== e.can_next) report("can_next", e.can_next, g.can_next);
          if (g.can_previous !== e.can_previous)
            report("can_previous", e.can_previous, g.can_previous);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TRACK_COUNT: begin
            count_q = cfg_data[COUNT_W-1:0];
            ready_q = 0;
            pos_q = 0;
          end
          REG_SHUFFLE_MODE: shuffle_q = cfg_data[0];
          REG_LOOP_ALL:     repeat_q = cfg_data[0];
          REG_RANDOM_SEED:  rng_q = (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata[1:0], s_axis_tdata[11:2]);
    end
    pending = expected_q.size();
  end
endmodule

// ===== sim/tb_shuffled_play_order.sv =====
// Testbench top for shuffled_play_order: clock, reset, operation stimulus,
// register writes, receiver stalls and verdict. Depends on spo_pkg and spo_checker.
module tb_shuffled_play_order;
  import spo_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // op[1:0], current_track[11:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // ok[0], track_index[10:1], can_next[11], can_previous[12]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int fails;
  int pending;
  int results_seen;
  int words_sent;
  int phases_run;
  int burst_left;
  int cycles;
  bit long_hold;
  int cur_count;

  shuffled_play_order u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spo_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending);
      $display("tb_shuffled_play_order: FAIL");
      $finish;
    end
  end

  // Receiver: rotate between always ready, light and heavy stalls; honor long holds.
  initial begin
    int rx_cycle;
    m_axis_tready = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else begin
        case ((rx_cycle / 64) % 3)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Hold the word until accepted; leave tvalid high while the burst lasts.
  task automatic send_word(input logic [1:0] op, input logic [9:0] cur);
    s_axis_tdata <= {4'd0, cur, op};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Drop tvalid and wait until every result word is back.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_TRACK_COUNT)
      cur_count = (val[10:0] > 11'(MAX_TRACKS)) ? MAX_TRACKS : int'(val[10:0]);
  endtask

  task automatic set_mode(input int count, input bit shuf, input bit rep);
    drain();
    write_reg(REG_TRACK_COUNT, 32'(count));
    write_reg(REG_SHUFFLE_MODE, 32'(shuf));
    write_reg(REG_LOOP_ALL, 32'(rep));
  endtask

  function automatic logic [9:0] valid_track();
    return (cur_count == 0) ? 10'd0 : 10'($urandom_range(0, cur_count - 1));
  endfunction

  initial begin
    int  n_items;
    int  roll;
    int  cnt;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    long_hold = 0;
    words_sent = 0;
    phases_run = 0;
    burst_left = 0;
    cycles = 0;
    cur_count = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Not ready, unknown op, empty table.
    send_word(OP_NEXT, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);
    send_word(OP_RESERVED, 10'h3FF);
    send_word(OP_ARRANGE, 10'd0);
    // Single track with repeat and shuffle.
    set_mode(1, 1, 1);
    send_word(OP_ARRANGE, 10'd0);
    send_word(OP_NEXT, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);
    // Linear order: stop at the ends, bad arranges.
    set_mode(5, 0, 0);
    send_word(OP_ARRANGE, 10'd4);
    send_word(OP_NEXT, 10'd0);
    send_word(OP_ARRANGE, 10'd5);
    send_word(OP_ARRANGE, 10'h3FF);
    send_word(OP_PREVIOUS, 10'd0);
    send_word(OP_ARRANGE, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);
    // Wrap both ways, then change shuffle mode without rearranging.
    drain();
    write_reg(REG_LOOP_ALL, 32'd1);
    write_reg(REG_RANDOM_SEED, 32'd0);
    send_word(OP_PREVIOUS, 10'd0);
    send_word(OP_NEXT, 10'd0);
    drain();
    write_reg(REG_SHUFFLE_MODE, 32'd1);
    send_word(OP_NEXT, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);
    // Oversized count, then the full table shuffled.
    set_mode(2047, 0, 1);
    send_word(OP_ARRANGE, 10'h3FF);
    send_word(OP_NEXT, 10'd0);
    set_mode(1024, 1, 1);
    write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
    send_word(OP_ARRANGE, 10'h3FF);
    send_word(OP_NEXT, 10'd0);
    send_word(OP_PREVIOUS, 10'd0);

    n_items = 0;
    while (n_items < 700) begin
      roll = $urandom_range(0, 19);
      cnt = (roll == 0) ? $urandom_range(100, 300) :
            (roll == 1) ? 0 : $urandom_range(1, 24);
      set_mode(cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      write_reg(REG_RANDOM_SEED, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom);
      phases_run++;
      if (phases_run == 3) long_hold = 1;
      send_word(OP_ARRANGE, valid_track());
      n_items++;
      repeat ($urandom_range(20, 60)) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) send_word(OP_NEXT, 10'($urandom));
        else if (roll < 82) send_word(OP_PREVIOUS, 10'($urandom));
        else if (roll < 90) send_word(OP_ARRANGE, valid_track());
        else if (roll < 96) send_word(OP_ARRANGE, 10'($urandom));
        else send_word(OP_RESERVED, 10'($urandom));
        n_items++;
      end
      if ($urandom_range(0, 4) == 0) begin
        // flip only the mode; the table stays as it is
        drain();
        write_reg(REG_SHUFFLE_MODE, $urandom_range(0, 1));
        repeat (10) send_word(($urandom_range(0, 1) == 1) ? OP_NEXT : OP_PREVIOUS, 10'd0);
        n_items += 10;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("sent %0d operation words over %0d random phases, %0d result words checked",
             words_sent, phases_run, results_seen);
    $display("covered arrange, next, previous, unknown op, wraps, reshuffles and stalls");
    if (fails == 0 && pending == 0) begin
      $display("tb_shuffled_play_order: PASS");
    end else begin
      $display("%0d mismatches, %0d words never returned", fails, pending);
      $display("tb_shuffled_play_order: FAIL");
    end
    $finish;
  end
endmodule
